### rtl/core/dltq_pkg.sv
// shared types and constants for the delta list timer queue
package dltq_pkg;

  localparam int DELTA_W         = 16;
  localparam int HANDLE_W        = 8;
  localparam int STATUS_W        = 2;
  localparam int DEF_QUEUE_DEPTH = 8;
  localparam int DEF_HANDLE_BITS = 8;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  localparam logic KIND_PUSH   = 1'b0;
  localparam logic KIND_EXPIRE = 1'b1;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } op_t;

  typedef struct packed {
    logic               valid;
    logic [DELTA_W-1:0] prev;
  } tok_t;

  typedef struct packed {
    op_t                op;
    logic               head;
    logic [DELTA_W-1:0] adj_delta;
  } cmd_t;

endpackage

### rtl/core/delta_list_timer_queue_unit.sv
// top level of the delta list timer queue: control sequencer and row of entry cells
//
// One-shot timer queue kept as a delta list in a row of QUEUE_DEPTH cells, cell 0 being
// the head. An expire, a push that becomes the new head, a push to a full queue and an
// expire on an empty queue are done in the accept cycle and give their result item on the
// next cycle. A push that lands behind the head sends a running-sum token down the cells,
// one cell per clock, starting at cell 0; the cell where the sum reaches the delay (or the
// first free cell) is the insertion point k, and the S_INSERT state then shifts the tail up.
// A new item is accepted only once the previous result item has been taken.
module delta_list_timer_queue_unit #(
  parameter int QUEUE_DEPTH = dltq_pkg::DEF_QUEUE_DEPTH,
  parameter int HANDLE_BITS = dltq_pkg::DEF_HANDLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_kind,
  input  logic [dltq_pkg::DELTA_W-1:0]  in_delay_ticks,
  input  logic [dltq_pkg::HANDLE_W-1:0] in_task_handle,
  input  logic [dltq_pkg::DELTA_W-1:0]  in_ticks_remaining,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_reload_valid,
  output logic [dltq_pkg::DELTA_W-1:0]  out_reload_ticks,
  output logic                          out_fired_valid,
  output logic [dltq_pkg::HANDLE_W-1:0] out_fired_handle,
  output logic [dltq_pkg::STATUS_W-1:0] out_status
);
  import dltq_pkg::*;

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int HB    = HANDLE_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [HB-1:0]       h_r, h_nxt;
  logic [DELTA_W-1:0]  d_r, d_nxt;
  logic [IDX_W-1:0]    k_r, k_nxt;
  logic [DELTA_W-1:0]  nd_r, nd_nxt;
  tok_t                inj_r, inj_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                rv_r, rv_nxt;
  logic [DELTA_W-1:0]  rt_r, rt_nxt;
  logic                fv_r, fv_nxt;
  logic [HANDLE_W-1:0] fh_r, fh_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;

  logic                     accept;
  logic                     full, empty, head_push;
  logic [HB+HANDLE_W-1:0]   in_h_ext, head_h_ext;
  logic [HB-1:0]            in_h;
  cmd_t                     cmd;
  logic [IDX_W-1:0]         ins_k;
  logic [HB-1:0]            ins_handle;
  logic [DELTA_W-1:0]       ins_delta;
  logic                     scan_hit;
  logic [IDX_W-1:0]         sel_k;
  logic [DELTA_W-1:0]       sel_prev;

  tok_t                     tok_c [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH-1:0]   hit_v;
  logic [QUEUE_DEPTH-1:0]   occ_v;
  logic [HB-1:0]            handle_q [QUEUE_DEPTH];
  logic [DELTA_W-1:0]       delta_q [QUEUE_DEPTH];

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state_r == S_IDLE) && !out_valid_r;
  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty      = (count_r == '0);
  assign head_push  = empty || (in_delay_ticks <= in_ticks_remaining);
  assign in_h_ext   = {{HB{1'b0}}, in_task_handle};
  assign in_h       = in_h_ext[HB-1:0];
  assign head_h_ext = {{HANDLE_W{1'b0}}, handle_q[0]};

  assign tok_c[0] = inj_r;

  genvar j;
  generate
    for (j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
      logic [HB-1:0]      lh, rh;
      logic [DELTA_W-1:0] ld, rd;

      assign occ_v[j] = (CNT_W'(j) < count_r);

      if (j == 0) begin : g_first
        assign lh = '0;
        assign ld = '0;
      end else begin : g_mid_l
        assign lh = handle_q[j-1];
        assign ld = delta_q[j-1];
      end

      if (j == QUEUE_DEPTH - 1) begin : g_last
        assign rh = '0;
        assign rd = '0;
      end else begin : g_mid_r
        assign rh = handle_q[j+1];
        assign rd = delta_q[j+1];
      end

      dltq_cell #(
        .IDX   (j),
        .IDX_W (IDX_W),
        .HB    (HB)
      ) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .occ          (occ_v[j]),
        .tok_in       (tok_c[j]),
        .tok_out      (tok_c[j+1]),
        .hit          (hit_v[j]),
        .cmd          (cmd),
        .ins_k        (ins_k),
        .ins_handle   (ins_handle),
        .ins_delta    (ins_delta),
        .req_delta    (d_r),
        .left_handle  (lh),
        .left_delta   (ld),
        .right_handle (rh),
        .right_delta  (rd),
        .handle_q     (handle_q[j]),
        .delta_q      (delta_q[j])
      );
    end
  endgenerate

  // insertion point from the one-hot hit vector
  always_comb begin
    sel_k    = '0;
    sel_prev = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (hit_v[i]) begin
        sel_k    = sel_k | IDX_W'(i);
        sel_prev = sel_prev | tok_c[i].prev;
      end
    end
    scan_hit = (|hit_v) || tok_c[QUEUE_DEPTH].valid;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    h_nxt         = h_r;
    d_nxt         = d_r;
    k_nxt         = k_r;
    nd_nxt        = nd_r;
    inj_nxt.valid = 1'b0;
    inj_nxt.prev  = inj_r.prev;
    out_valid_nxt = out_valid_r && !out_ready;
    rv_nxt        = rv_r;
    rt_nxt        = rt_r;
    fv_nxt        = fv_r;
    fh_nxt        = fh_r;
    st_nxt        = st_r;
    cmd.op        = OP_HOLD;
    cmd.head      = 1'b0;
    cmd.adj_delta = '0;
    ins_k         = k_r;
    ins_handle    = h_r;
    ins_delta     = nd_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          rv_nxt        = 1'b0;
          rt_nxt        = '0;
          fv_nxt        = 1'b0;
          fh_nxt        = '0;
          st_nxt        = ST_OK;
          if (in_kind == KIND_PUSH) begin
            if (full) begin
              st_nxt = ST_FULL;
            end else if (head_push) begin
              cmd.op        = OP_INSERT;
              cmd.head      = 1'b1;
              cmd.adj_delta = in_ticks_remaining - in_delay_ticks;
              ins_k         = '0;
              ins_handle    = in_h;
              ins_delta     = '0;
              count_nxt     = count_r + CNT_W'(1);
              rv_nxt        = 1'b1;
              rt_nxt        = in_delay_ticks;
            end else begin
              out_valid_nxt = 1'b0;
              h_nxt         = in_h;
              d_nxt         = in_delay_ticks;
              inj_nxt.valid = 1'b1;
              inj_nxt.prev  = in_ticks_remaining;
              state_nxt     = S_SCAN;
            end
          end else begin
            if (empty) begin
              st_nxt = ST_EMPTY;
            end else begin
              cmd.op    = OP_POP;
              count_nxt = count_r - CNT_W'(1);
              fv_nxt    = 1'b1;
              fh_nxt    = head_h_ext[HANDLE_W-1:0];
              if (count_r != CNT_W'(1)) begin
                rv_nxt = 1'b1;
                rt_nxt = delta_q[1];
              end
            end
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          k_nxt     = sel_k;
          nd_nxt    = d_r - sel_prev;
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.op        = OP_INSERT;
        count_nxt     = count_r + CNT_W'(1);
        out_valid_nxt = 1'b1;
        rv_nxt        = 1'b0;
        rt_nxt        = '0;
        fv_nxt        = 1'b0;
        fh_nxt        = '0;
        st_nxt        = ST_OK;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      inj_r.valid <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      inj_r.valid <= inj_nxt.valid;
      out_valid_r <= out_valid_nxt;
    end
    inj_r.prev <= inj_nxt.prev;
    h_r        <= h_nxt;
    d_r        <= d_nxt;
    k_r        <= k_nxt;
    nd_r       <= nd_nxt;
    rv_r       <= rv_nxt;
    rt_r       <= rt_nxt;
    fv_r       <= fv_nxt;
    fh_r       <= fh_nxt;
    st_r       <= st_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_reload_valid = rv_r;
  assign out_reload_ticks = rt_r;
  assign out_fired_valid  = fv_r;
  assign out_fired_handle = fh_r;
  assign out_status       = st_r;

endmodule

### rtl/core/dltq_cell.sv
// one queue entry: handle, delta, running-sum token stage and shift logic
module dltq_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 3,
  parameter int HB    = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        occ,
  input  dltq_pkg::tok_t              tok_in,
  output dltq_pkg::tok_t              tok_out,
  output logic                        hit,
  input  dltq_pkg::cmd_t              cmd,
  input  logic [IDX_W-1:0]            ins_k,
  input  logic [HB-1:0]               ins_handle,
  input  logic [dltq_pkg::DELTA_W-1:0] ins_delta,
  input  logic [dltq_pkg::DELTA_W-1:0] req_delta,
  input  logic [HB-1:0]               left_handle,
  input  logic [dltq_pkg::DELTA_W-1:0] left_delta,
  input  logic [HB-1:0]               right_handle,
  input  logic [dltq_pkg::DELTA_W-1:0] right_delta,
  output logic [HB-1:0]               handle_q,
  output logic [dltq_pkg::DELTA_W-1:0] delta_q
);
  import dltq_pkg::*;

  localparam logic [IDX_W:0] MY_IDX = (IDX_W+1)'(IDX);

  logic [HB-1:0]      handle_r, handle_nxt;
  logic [DELTA_W-1:0] delta_r, delta_nxt;
  tok_t               tok_r, tok_nxt;
  logic [DELTA_W:0]   sum_w;
  logic [DELTA_W-1:0] sat_w;
  logic               at_k, after_k, next_k;
  logic [IDX_W:0]     k_ext;

  assign k_ext   = {1'b0, ins_k};
  assign at_k    = (k_ext == MY_IDX);
  assign after_k = (k_ext < MY_IDX);
  assign next_k  = ((k_ext + (IDX_W+1)'(1)) == MY_IDX);

  // saturating running sum
  always_comb begin
    sum_w = {1'b0, tok_in.prev} + {1'b0, delta_r};
    sat_w = sum_w[DELTA_W] ? '1 : sum_w[DELTA_W-1:0];
  end

  // head cell only forwards the token
  always_comb begin
    if (MY_IDX == '0) begin
      hit          = 1'b0;
      tok_nxt.prev = tok_in.prev;
    end else begin
      hit          = tok_in.valid && (!occ || (sat_w >= req_delta));
      tok_nxt.prev = sat_w;
    end
    tok_nxt.valid = tok_in.valid && !hit;
  end

  always_comb begin
    handle_nxt = handle_r;
    delta_nxt  = delta_r;
    case (cmd.op)
      OP_INSERT: begin
        if (at_k) begin
          handle_nxt = ins_handle;
          delta_nxt  = ins_delta;
        end else if (after_k) begin
          handle_nxt = left_handle;
          if (next_k) begin
            delta_nxt = cmd.head ? cmd.adj_delta : (left_delta - ins_delta);
          end else begin
            delta_nxt = left_delta;
          end
        end
      end
      OP_POP: begin
        handle_nxt = right_handle;
        delta_nxt  = right_delta;
      end
      default: begin
        handle_nxt = handle_r;
        delta_nxt  = delta_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.prev <= tok_nxt.prev;
    handle_r   <= handle_nxt;
    delta_r    <= delta_nxt;
  end

  assign tok_out  = tok_r;
  assign handle_q = handle_r;
  assign delta_q  = delta_r;

endmodule
